// ===== hdl/blse_pkg.sv =====
// types and constants shared by the statement evaluator
package blse_pkg;

  localparam logic [2:0] ST_ASSIGN = 3'd0;
  localparam logic [2:0] ST_JUMP   = 3'd1;
  localparam logic [2:0] ST_NOJUMP = 3'd2;
  localparam logic [2:0] ST_PIN    = 3'd3;
  localparam logic [2:0] ST_ERROR  = 3'd4;

  localparam logic [1:0] OP_AND = 2'd0;
  localparam logic [1:0] OP_OR  = 2'd1;
  localparam logic [1:0] OP_XOR = 2'd2;

  localparam logic [1:0] DS_I = 2'd0;
  localparam logic [1:0] DS_O = 2'd1;
  localparam logic [1:0] DS_M = 2'd2;
  localparam logic [1:0] DS_T = 2'd3;

  localparam logic [15:0] MAX_TARGET = 16'd32767;
  localparam logic [15:0] MAX_PIN    = 16'd255;
  localparam logic [15:0] MAX_BIT    = 16'd7;
  localparam logic [15:0] MAX_CONST  = 16'd1;
  localparam logic [19:0] NUM_SAT    = 20'd65535;
  localparam logic [7:0]  PIN_RESET  = 8'd251;

  localparam logic [31:0] KW_GOTO = "GOTO";
  localparam logic [31:0] KW_NAND = "NAND";
  localparam logic [31:0] KW_XNOR = "XNOR";
  localparam logic [23:0] KW_PIN  = "PIN";
  localparam logic [23:0] KW_NOT  = "NOT";
  localparam logic [23:0] KW_AND  = "AND";
  localparam logic [23:0] KW_XOR  = "XOR";
  localparam logic [23:0] KW_NOR  = "NOR";
  localparam logic [15:0] KW_OR   = "OR";
  localparam logic [7:0]  CH_I    = "I";
  localparam logic [7:0]  CH_O    = "O";
  localparam logic [7:0]  CH_M    = "M";
  localparam logic [7:0]  CH_T    = "T";
  localparam logic [7:0]  CH_EQ   = "=";
  localparam logic [7:0]  CH_SP   = 8'd32;
  localparam logic [7:0]  CH_TAB  = 8'd9;
  localparam logic [7:0]  CH_CR   = 8'd13;
  localparam logic [7:0]  CH_NUL  = 8'd0;
  localparam logic [7:0]  CH_0    = "0";
  localparam logic [7:0]  CH_9    = "9";
  localparam logic [7:0]  CH_A    = "A";
  localparam logic [7:0]  CH_Z    = "Z";
  localparam logic [7:0]  CH_LA   = "a";
  localparam logic [7:0]  CH_LZ   = "z";
  localparam logic [7:0]  CASE_GAP = 8'd32;
  localparam logic [2:0]  WLEN_LONG = 3'd5;

  typedef enum logic [4:0] {
    E_HEAD, E_GNUM, E_GCOND, E_GBIT, E_GEND, E_PNUM, E_PEND, E_ABIT, E_EQ,
    E_EXPR, E_TERM, E_PTERM, E_FACT, E_FNUM, E_CNUM, E_OP, E_ERR
  } exp_t;

  typedef enum logic [1:0] {TK_NONE, TK_WORD, TK_NUM} tok_t;

  typedef enum logic [3:0] {
    W_OTHER, W_GOTO, W_PIN, W_NOT, W_AND, W_OR, W_XOR, W_NAND, W_NOR, W_XNOR,
    W_I, W_O, W_M, W_T
  } word_t;

  typedef struct packed {
    exp_t        exp;
    tok_t        tok;
    logic [31:0] word;
    logic [2:0]  wlen;
    logic [15:0] num;
    logic [14:0] target;
    logic        pre;
    logic [1:0]  op;
    logic        inv;
    logic        neg;
    logic        first;
    logic        acc;
    logic [1:0]  desig;
    logic [2:0]  abit;
    logic        to_out;
  } pst_t;

  localparam pst_t PST_RESET = '{exp: E_HEAD, tok: TK_NONE, default: '0};

  typedef struct packed {
    logic [7:0]  pin_address;
    logic [7:0]  mem_bits;
    logic [7:0]  out_bits;
    logic [14:0] jump_line;
    logic [2:0]  status;
  } res_t;

endpackage

// ===== hdl/bit_logic_statement_evaluator_top.sv =====
// statement evaluator: character parser, bit state and result buffer
//
// channel   dir  tdata (low bit up)                          tlast
// s_axis    in   text_char[7:0] in_port[15:8] tick_byte[23:16] last_char
// m_axis    out  status[2:0] jump_line[17:3] out_bits[25:18]  -
//                mem_bits[33:26] pin_address[41:34]
//
// one word per clock while s_axis_tready is high; each accepted character updates the parser state
// the final character of a statement also closes it and writes the result
// a two-entry result buffer keeps input flowing while a result waits
// s_axis_tready drops only when both result entries are full
// synchronous reset clears parser, bits (pin address 251) and buffer
module bit_logic_statement_evaluator_top #(
  parameter int STMT_CHARS = 50
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // text_char, in_port, tick_byte
  input  logic        s_axis_tlast,  // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // status, jump_line, out_bits, mem_bits, pin_address
);

  localparam int CNT_W = $clog2(STMT_CHARS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(STMT_CHARS - 1);

  blse_pkg::pst_t pst, p1, p2;
  logic [7:0]  latch, mem, pin;
  logic [15:0] captured;
  logic [CNT_W-1:0] char_count;
  logic        ended;
  logic        mid_stmt;

  logic        out_valid, spare_valid;
  blse_pkg::res_t out_res, spare_res, res;

  logic        accept, push, pop, first, keep;
  logic [7:0]  c, uc;
  logic [15:0] cap;
  logic [3:0][7:0] srcs;
  logic [CNT_W-1:0] count_eff;
  logic        ended_eff;
  logic [7:0]  latch_next, mem_next, pin_next;
  logic        val_bit;

  function automatic logic is_letter(input logic [7:0] ch);
    return ch >= blse_pkg::CH_A && ch <= blse_pkg::CH_Z;
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= blse_pkg::CH_0 && ch <= blse_pkg::CH_9;
  endfunction

  function automatic logic is_ws(input logic [7:0] ch);
    return ch == blse_pkg::CH_SP || (ch >= blse_pkg::CH_TAB && ch <= blse_pkg::CH_CR);
  endfunction

  function automatic blse_pkg::word_t classify(input logic [31:0] w, input logic [2:0] n);
    blse_pkg::word_t r;
    r = blse_pkg::W_OTHER;
    case (n)
      3'd1: begin
        if (w[7:0] == blse_pkg::CH_I) r = blse_pkg::W_I;
        else if (w[7:0] == blse_pkg::CH_O) r = blse_pkg::W_O;
        else if (w[7:0] == blse_pkg::CH_M) r = blse_pkg::W_M;
        else if (w[7:0] == blse_pkg::CH_T) r = blse_pkg::W_T;
      end
      3'd2: begin
        if (w[15:0] == blse_pkg::KW_OR) r = blse_pkg::W_OR;
      end
      3'd3: begin
        if (w[23:0] == blse_pkg::KW_PIN) r = blse_pkg::W_PIN;
        else if (w[23:0] == blse_pkg::KW_NOT) r = blse_pkg::W_NOT;
        else if (w[23:0] == blse_pkg::KW_AND) r = blse_pkg::W_AND;
        else if (w[23:0] == blse_pkg::KW_XOR) r = blse_pkg::W_XOR;
        else if (w[23:0] == blse_pkg::KW_NOR) r = blse_pkg::W_NOR;
      end
      3'd4: begin
        if (w == blse_pkg::KW_GOTO) r = blse_pkg::W_GOTO;
        else if (w == blse_pkg::KW_NAND) r = blse_pkg::W_NAND;
        else if (w == blse_pkg::KW_XNOR) r = blse_pkg::W_XNOR;
      end
      default: r = blse_pkg::W_OTHER;
    endcase
    return r;
  endfunction

  function automatic logic combine(input logic [1:0] op, input logic a, input logic b);
    logic r;
    case (op)
      blse_pkg::OP_AND: r = a & b;
      blse_pkg::OP_OR:  r = a | b;
      default:          r = a ^ b;
    endcase
    return r;
  endfunction

  function automatic blse_pkg::pst_t apply_term(input blse_pkg::pst_t p, input logic v);
    blse_pkg::pst_t r;
    logic t;
    r = p;
    t = v ^ p.neg;
    r.neg = 1'b0;
    r.first = 1'b0;
    r.acc = p.first ? t : combine(p.op, p.acc, t);
    if (!p.pre) r.exp = blse_pkg::E_OP;
    else if (p.first) r.exp = blse_pkg::E_TERM;
    else r.exp = blse_pkg::E_PTERM;
    return r;
  endfunction

  function automatic blse_pkg::pst_t close_tok(input blse_pkg::pst_t p, input logic dig,
                                               input logic [3:0][7:0] sv);
    blse_pkg::pst_t r;
    blse_pkg::word_t wc;
    logic kw, isd;
    logic [1:0] dc;
    logic [7:0] src;
    r = p;
    r.tok = blse_pkg::TK_NONE;
    wc = classify(p.word, p.wlen);
    kw = !dig;
    isd = wc == blse_pkg::W_I || wc == blse_pkg::W_O || wc == blse_pkg::W_M ||
          wc == blse_pkg::W_T;
    case (wc)
      blse_pkg::W_O: dc = blse_pkg::DS_O;
      blse_pkg::W_M: dc = blse_pkg::DS_M;
      blse_pkg::W_T: dc = blse_pkg::DS_T;
      default:       dc = blse_pkg::DS_I;
    endcase
    src = sv[p.desig];
    if (p.tok == blse_pkg::TK_NUM) begin
      unique case (p.exp)
        blse_pkg::E_GNUM: begin
          if (p.num > blse_pkg::MAX_TARGET) r.exp = blse_pkg::E_ERR;
          else begin
            r.target = p.num[14:0];
            r.exp = blse_pkg::E_GCOND;
          end
        end
        blse_pkg::E_GBIT: begin
          if (p.num > blse_pkg::MAX_BIT) r.exp = blse_pkg::E_ERR;
          else begin
            r.acc = src[p.num[2:0]];
            r.exp = blse_pkg::E_GEND;
          end
        end
        blse_pkg::E_PNUM: begin
          if (p.num > blse_pkg::MAX_PIN) r.exp = blse_pkg::E_ERR;
          else begin
            r.target = {7'd0, p.num[7:0]};
            r.exp = blse_pkg::E_PEND;
          end
        end
        blse_pkg::E_ABIT: begin
          if (p.num > blse_pkg::MAX_BIT) r.exp = blse_pkg::E_ERR;
          else begin
            r.abit = p.num[2:0];
            r.exp = blse_pkg::E_EQ;
          end
        end
        blse_pkg::E_FNUM: begin
          if (p.num > blse_pkg::MAX_BIT) r.exp = blse_pkg::E_ERR;
          else r = apply_term(r, src[p.num[2:0]]);
        end
        blse_pkg::E_CNUM: begin
          if (p.num > blse_pkg::MAX_CONST) r.exp = blse_pkg::E_ERR;
          else r = apply_term(r, p.num[0]);
        end
        default: r.exp = blse_pkg::E_ERR;
      endcase
    end else if (p.tok == blse_pkg::TK_WORD) begin
      unique case (p.exp) inside
        blse_pkg::E_HEAD: begin
          if (kw && wc == blse_pkg::W_GOTO) r.exp = blse_pkg::E_GNUM;
          else if (kw && wc == blse_pkg::W_PIN) r.exp = blse_pkg::E_PNUM;
          else if (wc == blse_pkg::W_O || wc == blse_pkg::W_M) begin
            r.to_out = wc == blse_pkg::W_O;
            r.exp = blse_pkg::E_ABIT;
          end else r.exp = blse_pkg::E_ERR;
        end
        blse_pkg::E_GCOND, blse_pkg::E_FACT: begin
          if (isd) begin
            r.desig = dc;
            r.exp = (p.exp == blse_pkg::E_GCOND) ? blse_pkg::E_GBIT : blse_pkg::E_FNUM;
          end else r.exp = blse_pkg::E_ERR;
        end
        blse_pkg::E_EXPR, blse_pkg::E_TERM, blse_pkg::E_PTERM: begin
          if (kw && p.exp == blse_pkg::E_EXPR &&
              (wc == blse_pkg::W_AND || wc == blse_pkg::W_OR || wc == blse_pkg::W_XOR ||
               wc == blse_pkg::W_NAND || wc == blse_pkg::W_NOR || wc == blse_pkg::W_XNOR)) begin
            r.pre = 1'b1;
            r.inv = wc == blse_pkg::W_NAND || wc == blse_pkg::W_NOR || wc == blse_pkg::W_XNOR;
            if (wc == blse_pkg::W_AND || wc == blse_pkg::W_NAND) r.op = blse_pkg::OP_AND;
            else if (wc == blse_pkg::W_OR || wc == blse_pkg::W_NOR) r.op = blse_pkg::OP_OR;
            else r.op = blse_pkg::OP_XOR;
            r.exp = blse_pkg::E_TERM;
          end else if (kw && wc == blse_pkg::W_NOT) begin
            r.neg = 1'b1;
            r.exp = blse_pkg::E_FACT;
          end else if (isd) begin
            r.desig = dc;
            r.exp = blse_pkg::E_FNUM;
          end else r.exp = blse_pkg::E_ERR;
        end
        blse_pkg::E_OP: begin
          if (kw && (wc == blse_pkg::W_AND || wc == blse_pkg::W_OR || wc == blse_pkg::W_XOR)) begin
            if (wc == blse_pkg::W_AND) r.op = blse_pkg::OP_AND;
            else if (wc == blse_pkg::W_OR) r.op = blse_pkg::OP_OR;
            else r.op = blse_pkg::OP_XOR;
            r.exp = blse_pkg::E_TERM;
          end else r.exp = blse_pkg::E_ERR;
        end
        default: r.exp = blse_pkg::E_ERR;
      endcase
    end
    return r;
  endfunction

  function automatic blse_pkg::pst_t step_char(input blse_pkg::pst_t p, input logic [7:0] ch,
                                               input logic [3:0][7:0] sv);
    blse_pkg::pst_t r;
    logic [19:0] m;
    logic lt, dg;
    r = p;
    lt = is_letter(ch);
    dg = is_digit(ch);
    m = ({4'd0, p.num} << 3) + ({4'd0, p.num} << 1) + {16'd0, ch[3:0]};
    if (p.exp == blse_pkg::E_ERR) begin
      r = p;
    end else if (p.tok == blse_pkg::TK_WORD && lt) begin
      r.word = {p.word[23:0], ch};
      if (p.wlen != blse_pkg::WLEN_LONG) r.wlen = p.wlen + 3'd1;
    end else if (p.tok == blse_pkg::TK_NUM && dg) begin
      r.num = (m > blse_pkg::NUM_SAT) ? 16'hFFFF : m[15:0];
    end else begin
      if (p.tok != blse_pkg::TK_NONE) r = close_tok(p, dg, sv);
      if (r.exp != blse_pkg::E_ERR && !is_ws(ch)) begin
        if (lt) begin
          case (r.exp) inside
            blse_pkg::E_HEAD, blse_pkg::E_GCOND, blse_pkg::E_EXPR, blse_pkg::E_TERM,
            blse_pkg::E_PTERM, blse_pkg::E_FACT, blse_pkg::E_OP: begin
              r.tok = blse_pkg::TK_WORD;
              r.word = {24'd0, ch};
              r.wlen = 3'd1;
            end
            default: r.exp = blse_pkg::E_ERR;
          endcase
        end else if (dg) begin
          case (r.exp) inside
            blse_pkg::E_GNUM, blse_pkg::E_GBIT, blse_pkg::E_PNUM, blse_pkg::E_ABIT,
            blse_pkg::E_FNUM: begin
              r.tok = blse_pkg::TK_NUM;
              r.num = {12'd0, ch[3:0]};
            end
            blse_pkg::E_EXPR, blse_pkg::E_TERM, blse_pkg::E_PTERM, blse_pkg::E_FACT: begin
              r.exp = blse_pkg::E_CNUM;
              r.tok = blse_pkg::TK_NUM;
              r.num = {12'd0, ch[3:0]};
            end
            default: r.exp = blse_pkg::E_ERR;
          endcase
        end else if (ch == blse_pkg::CH_EQ && r.exp == blse_pkg::E_EQ) begin
          r.exp = blse_pkg::E_EXPR;
          r.pre = 1'b0;
          r.first = 1'b1;
          r.neg = 1'b0;
        end else begin
          r.exp = blse_pkg::E_ERR;
        end
      end
    end
    return r;
  endfunction

  assign accept = s_axis_tvalid && s_axis_tready;
  assign push = accept && s_axis_tlast;
  assign pop = out_valid && m_axis_tready;
  assign s_axis_tready = !spare_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {6'd0, out_res};

  // character capture and parser next state
  always_comb begin
    first = !mid_stmt;
    c = s_axis_tdata[7:0];
    uc = (c >= blse_pkg::CH_LA && c <= blse_pkg::CH_LZ) ? c - blse_pkg::CASE_GAP : c;
    cap = first ? s_axis_tdata[23:8] : captured;
    srcs = {cap[15:8], mem, latch, cap[7:0]};
    count_eff = first ? '0 : char_count;
    ended_eff = first ? 1'b0 : ended;
    keep = c != blse_pkg::CH_NUL && !ended_eff && count_eff != CNT_MAX;
    p1 = keep ? step_char(pst, uc, srcs) : pst;
    p2 = (p1.tok != blse_pkg::TK_NONE && p1.exp != blse_pkg::E_ERR) ?
         close_tok(p1, 1'b0, srcs) : p1;
  end

  // statement result
  always_comb begin
    res.status = blse_pkg::ST_ERROR;
    res.jump_line = '0;
    latch_next = latch;
    mem_next = mem;
    pin_next = pin;
    val_bit = (p2.exp == blse_pkg::E_PTERM) ? (p2.acc ^ p2.inv) : p2.acc;
    unique case (p2.exp) inside
      blse_pkg::E_GCOND: begin
        res.status = blse_pkg::ST_JUMP;
        res.jump_line = p2.target;
      end
      blse_pkg::E_GEND: begin
        res.status = p2.acc ? blse_pkg::ST_JUMP : blse_pkg::ST_NOJUMP;
        res.jump_line = p2.acc ? p2.target : '0;
      end
      blse_pkg::E_PEND: begin
        res.status = blse_pkg::ST_PIN;
        pin_next = p2.target[7:0];
      end
      blse_pkg::E_OP, blse_pkg::E_PTERM: begin
        res.status = blse_pkg::ST_ASSIGN;
        if (p2.to_out) latch_next[p2.abit] = val_bit;
        else mem_next[p2.abit] = val_bit;
      end
      default: res.status = blse_pkg::ST_ERROR;
    endcase
    res.out_bits = latch_next;
    res.mem_bits = mem_next;
    res.pin_address = pin_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pst <= blse_pkg::PST_RESET;
      latch <= '0;
      mem <= '0;
      pin <= blse_pkg::PIN_RESET;
      captured <= '0;
      char_count <= '0;
      ended <= 1'b0;
      mid_stmt <= 1'b0;
    end else if (accept) begin
      captured <= cap;
      char_count <= (keep) ? count_eff + 1'b1 : count_eff;
      ended <= ended_eff || c == blse_pkg::CH_NUL;
      if (s_axis_tlast) begin
        pst <= blse_pkg::PST_RESET;
        mid_stmt <= 1'b0;
        latch <= latch_next;
        mem <= mem_next;
        pin <= pin_next;
      end else begin
        pst <= p1;
        mid_stmt <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      spare_valid <= 1'b0;
    end else if (spare_valid) begin
      if (pop) spare_valid <= 1'b0;
    end else if (push) begin
      if (out_valid && !pop) spare_valid <= 1'b1;
      else out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (spare_valid) begin
      if (pop) out_res <= spare_res;
    end else if (push) begin
      if (out_valid && !pop) spare_res <= res;
      else out_res <= res;
    end
  end

`ifndef SYNTH
  a_spare_behind_out: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> out_valid)
    else $error("spare word held with empty output");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.status <= blse_pkg::ST_ERROR))
    else $error("status code out of range");

  a_jump_only_taken: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.status != blse_pkg::ST_JUMP) |-> (out_res.jump_line == '0))
    else $error("jump line set without jump");

  a_head_after_last: assert property (@(posedge clk) disable iff (rst)
    push |=> (pst.exp == blse_pkg::E_HEAD && !mid_stmt))
    else $error("parser not back at statement start");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    char_count <= CNT_MAX)
    else $error("character count past limit");
`endif

endmodule
